FILE: sv/upre_pkg.sv
// shared types, constants and decode functions of the printable run extractor
package upre_pkg;

  localparam int MAX_MIN_LENGTH_DEF = 8;
  localparam int BUFFER_BYTES_DEF   = 32;
  localparam int RING_DEPTH_DEF     = 64;
  localparam int CMD_DEPTH          = 4;
  localparam int BYTE_W             = 8;
  localparam int POS_W              = 64;
  localparam int CP_W               = 21;
  localparam int ST_W               = 4;
  localparam int CLS_W              = 4;
  localparam int KIND_W             = 2;
  // widest ring pointer and byte count over the legal buffer sizes
  localparam int PTR_W              = 7;
  localparam int CNT_W              = 6;
  localparam int CFG_IDX_W          = 2;
  localparam int CFG_DATA_W         = 4;

  localparam logic [CFG_DATA_W-1:0] MIN_LENGTH_RST = 4'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_LENGTH = 2'd0,
    CFG_OFFSET_EN  = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    REQ_DATA = 1'b0,
    REQ_EOS  = 1'b1
  } req_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA     = 2'd0,
    KIND_OFFSET   = 2'd1,
    KIND_END      = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_e;

  localparam logic [ST_W-1:0] ST_ACCEPT = 4'd0;
  localparam logic [ST_W-1:0] ST_REJECT = 4'd1;

  // decoder transitions, row per state, column per byte class
  localparam logic [ST_W-1:0] NEXT_STATE [0:143] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1
  };

  typedef struct packed {
    logic               pre_valid;
    kind_e              pre_kind;
    logic               off_valid;
    logic [POS_W-1:0]   offset;
    logic [CNT_W-1:0]   count;
    logic [PTR_W-1:0]   ptr;
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic [PTR_W-1:0] ptr;
  } hold_t;

  function automatic logic [CLS_W-1:0] byte_class(input logic [BYTE_W-1:0] b);
    logic [CLS_W-1:0] c;
    priority if (b < 8'h80) c = 4'd0;
    else if (b < 8'h90) c = 4'd1;
    else if (b < 8'hA0) c = 4'd9;
    else if (b < 8'hC0) c = 4'd7;
    else if (b < 8'hC2) c = 4'd8;
    else if (b < 8'hE0) c = 4'd2;
    else if (b == 8'hE0) c = 4'd10;
    else if (b == 8'hED) c = 4'd4;
    else if (b < 8'hF0) c = 4'd3;
    else if (b == 8'hF0) c = 4'd11;
    else if (b < 8'hF4) c = 4'd6;
    else if (b == 8'hF4) c = 4'd5;
    else c = 4'd8;
    return c;
  endfunction

  function automatic logic [ST_W-1:0] dfa_next(input logic [ST_W-1:0] st,
                                               input logic [CLS_W-1:0] cls);
    logic [ST_W-1:0] s;
    s = (st > 4'd8) ? ST_REJECT : st;
    return NEXT_STATE[{s, cls}];
  endfunction

  function automatic logic printable(input logic [CP_W-1:0] cp);
    logic p;
    priority if (cp == 21'h09) p = 1'b1;
    else if (cp < 21'h20) p = 1'b0;
    else if (cp >= 21'h7F && cp < 21'hA0) p = 1'b0;
    else p = 1'b1;
    return p;
  endfunction

endpackage

FILE: sv/upre_intf.sv
// handshake channel interfaces: configuration writes, input bytes, results
interface upre_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [upre_pkg::CFG_IDX_W-1:0]   index;
  logic [upre_pkg::CFG_DATA_W-1:0]  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

interface upre_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [upre_pkg::BYTE_W-1:0]  data_byte;
  modport source(output valid, req_type, data_byte, input ready);
  modport sink(input valid, req_type, data_byte, output ready);
endinterface

interface upre_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [upre_pkg::KIND_W-1:0]  kind;
  logic [upre_pkg::BYTE_W-1:0]  out_byte;
  logic [upre_pkg::POS_W-1:0]   run_offset;
  logic                         last;
  modport source(output valid, kind, out_byte, run_offset, last, input ready);
  modport sink(input valid, kind, out_byte, run_offset, last, output ready);
endinterface

FILE: sv/upre_ram.sv
// generic single write port, single read port ram with registered read
module upre_ram #(
  parameter int WIDTH = upre_pkg::BYTE_W,
  parameter int DEPTH = upre_pkg::RING_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: sv/upre_cmd_fifo.sv
// short command queue between the decode front end and the emit back end
module upre_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  upre_pkg::cmd_t  cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output upre_pkg::cmd_t  cmd_o,
  output logic            empty_o
);

  localparam int AW = $clog2(upre_pkg::CMD_DEPTH);
  localparam int CW = $clog2(upre_pkg::CMD_DEPTH + 1);

  upre_pkg::cmd_t  mem_q [upre_pkg::CMD_DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push, do_pop;

  always_comb begin
    full_o   = (count_q == CW'(upre_pkg::CMD_DEPTH));
    empty_o  = (count_q == '0);
    do_push  = push_i && !full_o;
    do_pop   = pop_i && !empty_o;
    wr_ptr_d = do_push ? wr_ptr_q + AW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + AW'(1) : rd_ptr_q;
    count_d  = count_q + CW'(do_push) - CW'(do_pop);
    cmd_o    = mem_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: sv/upre_front.sv
// front end: accepts bytes, decodes utf-8, tracks runs and issues emit commands
module upre_front #(
  parameter int MAX_MIN_LENGTH = upre_pkg::MAX_MIN_LENGTH_DEF,
  parameter int BUFFER_BYTES   = upre_pkg::BUFFER_BYTES_DEF,
  localparam int RAW = $clog2(BUFFER_BYTES) + 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic                              req_type_i,
  input  logic [upre_pkg::BYTE_W-1:0]       data_byte_i,
  input  logic [upre_pkg::CFG_DATA_W-1:0]   min_length_i,
  input  logic                              offset_enable_i,
  output logic                              wr_en_o,
  output logic [RAW-1:0]                    wr_addr_o,
  output logic [upre_pkg::BYTE_W-1:0]       wr_data_o,
  output logic                              push_o,
  output upre_pkg::cmd_t                    cmd_o,
  input  logic                              full_i,
  input  upre_pkg::hold_t                   hold_i
);

  localparam int LIM_CAP = (MAX_MIN_LENGTH < BUFFER_BYTES / 4) ? MAX_MIN_LENGTH
                                                               : BUFFER_BYTES / 4;
  localparam int CHW  = $clog2(LIM_CAP + 2);
  localparam int BUFW = $clog2(BUFFER_BYTES + 1);

  logic [upre_pkg::ST_W-1:0]  dfa_q, dfa_d;
  logic [upre_pkg::CP_W-1:0]  cp_q, cp_d;
  logic [BUFW-1:0]            buf_q, buf_d;
  logic [CHW-1:0]             chars_q, chars_d;
  logic                       new_q, new_d;
  logic [upre_pkg::POS_W-1:0] pos_q, pos_d;
  logic                       ovf_q, ovf_d;
  logic [RAW-1:0]             head_q, head_d;
  logic [RAW-1:0]             run_ptr_q, run_ptr_d;

  logic [CHW-1:0]             lim;
  logic                       at_limit;
  logic [RAW-1:0]             oldest;
  logic [RAW-1:0]             used;
  logic                       accept;
  logic [upre_pkg::CLS_W-1:0] cls;
  logic [upre_pkg::BYTE_W-1:0] mask;
  logic [upre_pkg::CP_W-1:0]  lead_cp;
  logic [upre_pkg::CP_W-1:0]  cp_a;
  logic [upre_pkg::ST_W-1:0]  st_a, st_b, st_f;
  logic                       reject, lead_bad, keep, wr, flush, end_hit;
  logic [BUFW-1:0]            buf_b, buf1, off_sub;
  logic [CHW-1:0]             chars_b, chars1;
  logic                       new_b;
  logic [RAW-1:0]             rp_b, head1;

  always_comb begin
    if (min_length_i == '0) begin
      lim = CHW'(1);
    end else if (min_length_i > upre_pkg::CFG_DATA_W'(LIM_CAP)) begin
      lim = CHW'(LIM_CAP);
    end else begin
      lim = CHW'(min_length_i);
    end

    at_limit = offset_enable_i && (&pos_q);
    oldest   = hold_i.valid ? hold_i.ptr[RAW-1:0] : run_ptr_q;
    used     = head_q - oldest;
    ready_o  = !full_i && (used != '1);
    accept   = valid_i && ready_o;

    // decode of the byte against the running sequence
    cls     = upre_pkg::byte_class(data_byte_i);
    mask    = 8'hFF >> cls;
    lead_cp = upre_pkg::CP_W'(data_byte_i & mask);
    cp_a    = (dfa_q == upre_pkg::ST_ACCEPT) ? lead_cp : {cp_q[14:0], data_byte_i[5:0]};
    st_a    = upre_pkg::dfa_next(dfa_q, cls);
    if (st_a == upre_pkg::ST_ACCEPT && !upre_pkg::printable(cp_a)) begin
      st_a = upre_pkg::ST_REJECT;
    end
    reject = (st_a == upre_pkg::ST_REJECT);

    // same byte taken again as a lead byte
    st_b     = upre_pkg::dfa_next(upre_pkg::ST_ACCEPT, cls);
    lead_bad = (st_b == upre_pkg::ST_REJECT) ||
               (st_b == upre_pkg::ST_ACCEPT && !upre_pkg::printable(lead_cp));
    st_f     = reject ? (lead_bad ? upre_pkg::ST_ACCEPT : st_b) : st_a;
    keep     = !(reject && lead_bad);

    buf_b   = reject ? '0 : buf_q;
    chars_b = reject ? '0 : chars_q;
    new_b   = reject ? 1'b1 : new_q;
    rp_b    = reject ? head_q : run_ptr_q;

    wr      = keep && (buf_b < BUFW'(BUFFER_BYTES));
    buf1    = buf_b + BUFW'(wr);
    head1   = head_q + RAW'(wr);
    chars1  = chars_b + CHW'(1);
    flush   = keep && (st_f == upre_pkg::ST_ACCEPT) && (chars1 >= lim);
    end_hit = reject && (chars_q >= lim);
    off_sub = buf1 - BUFW'(1);

    dfa_d     = dfa_q;
    cp_d      = cp_q;
    buf_d     = buf_q;
    chars_d   = chars_q;
    new_d     = new_q;
    pos_d     = pos_q;
    ovf_d     = ovf_q;
    head_d    = head_q;
    run_ptr_d = run_ptr_q;

    wr_en_o   = 1'b0;
    wr_addr_o = head_q;
    wr_data_o = data_byte_i;
    push_o    = 1'b0;
    cmd_o     = '0;
    cmd_o.ptr = upre_pkg::PTR_W'(head_q);

    if (accept) begin
      if (req_type_i == upre_pkg::REQ_EOS) begin
        if (!ovf_q) begin
          if (at_limit) begin
            push_o           = 1'b1;
            cmd_o.pre_valid  = 1'b1;
            cmd_o.pre_kind   = upre_pkg::KIND_OVERFLOW;
          end else if (chars_q >= lim) begin
            push_o           = 1'b1;
            cmd_o.pre_valid  = 1'b1;
            cmd_o.pre_kind   = upre_pkg::KIND_END;
          end
        end
        dfa_d     = upre_pkg::ST_ACCEPT;
        cp_d      = '0;
        buf_d     = '0;
        chars_d   = '0;
        new_d     = 1'b1;
        pos_d     = '0;
        ovf_d     = 1'b0;
        run_ptr_d = head_q;
      end else if (!ovf_q) begin
        if (at_limit) begin
          ovf_d           = 1'b1;
          push_o          = 1'b1;
          cmd_o.pre_valid = 1'b1;
          cmd_o.pre_kind  = upre_pkg::KIND_OVERFLOW;
          cmd_o.ptr       = upre_pkg::PTR_W'(run_ptr_q);
        end else begin
          pos_d   = pos_q + upre_pkg::POS_W'(1);
          dfa_d   = st_f;
          cp_d    = reject ? lead_cp : cp_a;
          wr_en_o = wr;
          head_d  = head1;
          chars_d = chars_b;
          if (keep && st_f == upre_pkg::ST_ACCEPT) begin
            chars_d = flush ? lim : chars1;
          end
          cmd_o.ptr       = upre_pkg::PTR_W'(rp_b);
          cmd_o.pre_valid = end_hit;
          cmd_o.pre_kind  = upre_pkg::KIND_END;
          push_o          = end_hit || flush;
          if (flush) begin
            buf_d           = '0;
            new_d           = 1'b0;
            run_ptr_d       = head1;
            cmd_o.count     = upre_pkg::CNT_W'(buf1);
            cmd_o.off_valid = new_b && offset_enable_i;
            cmd_o.offset    = pos_q - upre_pkg::POS_W'(off_sub);
          end else begin
            buf_d     = buf1;
            new_d     = new_b;
            run_ptr_d = rp_b;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dfa_q     <= upre_pkg::ST_ACCEPT;
      cp_q      <= '0;
      buf_q     <= '0;
      chars_q   <= '0;
      new_q     <= 1'b1;
      pos_q     <= '0;
      ovf_q     <= 1'b0;
      head_q    <= '0;
      run_ptr_q <= '0;
    end else begin
      dfa_q     <= dfa_d;
      cp_q      <= cp_d;
      buf_q     <= buf_d;
      chars_q   <= chars_d;
      new_q     <= new_d;
      pos_q     <= pos_d;
      ovf_q     <= ovf_d;
      head_q    <= head_d;
      run_ptr_q <= run_ptr_d;
    end
  end

endmodule

FILE: sv/upre_back.sv
// back end: works through commands, reads ring bytes and drives the result register
module upre_back #(
  parameter int BUFFER_BYTES = upre_pkg::BUFFER_BYTES_DEF,
  localparam int RAW = $clog2(BUFFER_BYTES) + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  upre_pkg::cmd_t                cmd_i,
  output logic                          pop_o,
  output upre_pkg::hold_t               hold_o,
  output logic                          rd_en_o,
  output logic [RAW-1:0]                rd_addr_o,
  input  logic [upre_pkg::BYTE_W-1:0]   rd_data_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [upre_pkg::KIND_W-1:0]   kind_o,
  output logic [upre_pkg::BYTE_W-1:0]   out_byte_o,
  output logic [upre_pkg::POS_W-1:0]    run_offset_o,
  output logic                          last_o
);

  localparam int BUFW = $clog2(BUFFER_BYTES + 1);

  logic                       busy_q, busy_d;
  logic                       pre_q, pre_d;
  logic                       off_q, off_d;
  logic [BUFW-1:0]            cnt_q, cnt_d;
  logic [RAW-1:0]             ptr_q, ptr_d;
  logic                       s1_valid_q, s1_valid_d;
  logic                       out_valid_q, out_valid_d;

  upre_pkg::kind_e            pre_kind_q;
  logic [upre_pkg::POS_W-1:0] offset_q;
  upre_pkg::kind_e            s1_kind_q;
  logic                       s1_last_q;
  logic [upre_pkg::POS_W-1:0] s1_offset_q;
  upre_pkg::kind_e            out_kind_q;
  logic [upre_pkg::BYTE_W-1:0] out_byte_q;
  logic [upre_pkg::POS_W-1:0] out_offset_q;
  logic                       out_last_q;

  logic                       out_load, s1_free, issue, item_last;
  upre_pkg::kind_e            item_kind;

  always_comb begin
    out_load = !out_valid_q || ready_i;
    s1_free  = !s1_valid_q || out_load;
    issue    = busy_q && s1_free;

    if (pre_q) begin
      item_kind = pre_kind_q;
      item_last = !off_q && (cnt_q == '0);
    end else if (off_q) begin
      item_kind = upre_pkg::KIND_OFFSET;
      item_last = (cnt_q == '0);
    end else begin
      item_kind = upre_pkg::KIND_DATA;
      item_last = (cnt_q == BUFW'(1));
    end

    rd_en_o   = issue && !pre_q && !off_q;
    rd_addr_o = ptr_q;
    pop_o     = !empty_i && (!busy_q || (issue && item_last));

    hold_o.valid = busy_q || !empty_i;
    hold_o.ptr   = busy_q ? upre_pkg::PTR_W'(ptr_q) : cmd_i.ptr;

    busy_d = busy_q;
    pre_d  = pre_q;
    off_d  = off_q;
    cnt_d  = cnt_q;
    ptr_d  = ptr_q;
    if (issue) begin
      if (pre_q) begin
        pre_d = 1'b0;
      end else if (off_q) begin
        off_d = 1'b0;
      end else begin
        cnt_d = cnt_q - BUFW'(1);
        ptr_d = ptr_q + RAW'(1);
      end
      if (item_last) begin
        busy_d = 1'b0;
      end
    end
    if (pop_o) begin
      busy_d = 1'b1;
      pre_d  = cmd_i.pre_valid;
      off_d  = cmd_i.off_valid;
      cnt_d  = cmd_i.count[BUFW-1:0];
      ptr_d  = cmd_i.ptr[RAW-1:0];
    end

    s1_valid_d  = s1_free ? issue : s1_valid_q;
    out_valid_d = out_load ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pre_q       <= 1'b0;
      off_q       <= 1'b0;
      cnt_q       <= '0;
      ptr_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pre_q       <= pre_d;
      off_q       <= off_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pre_kind_q <= cmd_i.pre_kind;
      offset_q   <= cmd_i.offset;
    end
    if (issue) begin
      s1_kind_q   <= item_kind;
      s1_last_q   <= item_last;
      s1_offset_q <= (item_kind == upre_pkg::KIND_OFFSET) ? offset_q : '0;
    end
    if (out_load && s1_valid_q) begin
      out_kind_q   <= s1_kind_q;
      out_byte_q   <= (s1_kind_q == upre_pkg::KIND_DATA) ? rd_data_i : '0;
      out_offset_q <= s1_offset_q;
      out_last_q   <= s1_last_q;
    end
  end

  assign valid_o      = out_valid_q;
  assign kind_o       = out_kind_q;
  assign out_byte_o   = out_byte_q;
  assign run_offset_o = out_offset_q;
  assign last_o       = out_last_q;

endmodule

FILE: sv/utf8_printable_run_extractor_unit.sv
// top level of the utf-8 printable run extractor
//
// Takes one byte (or end of stream) per cycle unless input is held off, and decodes it
// combinationally in the front end, which keeps the bytes of the open run in a ring of
// 2 * 2**ceil(log2(BUFFER_BYTES)) bytes and posts an emit command to a 4-entry queue
// whenever a run must be flushed, closed or an offset overflow reported. The back end
// turns each command into results at one per cycle unless the result side stalls, through
// the ring's single read port and the back end's s1 and output registers, so a command
// yields up to BUFFER_BYTES + 1 results. Input is held off only while the command queue
// is full or the ring holds bytes of the open run or not yet read by the back end up to
// its size less one. Configuration writes take effect at once and are meant to be made with the block idle.
module utf8_printable_run_extractor_unit #(
  parameter int MAX_MIN_LENGTH = upre_pkg::MAX_MIN_LENGTH_DEF,
  parameter int BUFFER_BYTES   = upre_pkg::BUFFER_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  upre_cfg_if.sink    cfg_i,
  upre_req_if.sink    req_i,
  upre_rsp_if.source  rsp_o
);

  localparam int RAW        = $clog2(BUFFER_BYTES) + 1;
  localparam int RING_DEPTH = 2 ** RAW;

  logic [upre_pkg::CFG_DATA_W-1:0] min_length_q;
  logic                            offset_enable_q;

  logic                        wr_en;
  logic [RAW-1:0]              wr_addr;
  logic [upre_pkg::BYTE_W-1:0] wr_data;
  logic                        rd_en;
  logic [RAW-1:0]              rd_addr;
  logic [upre_pkg::BYTE_W-1:0] rd_data;
  logic                        push, pop, full, empty;
  upre_pkg::cmd_t              push_cmd, head_cmd;
  upre_pkg::hold_t             hold;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_length_q    <= upre_pkg::MIN_LENGTH_RST;
      offset_enable_q <= 1'b0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == upre_pkg::CFG_MIN_LENGTH) begin
        min_length_q <= cfg_i.data;
      end
      if (cfg_i.index == upre_pkg::CFG_OFFSET_EN) begin
        offset_enable_q <= cfg_i.data[0];
      end
    end
  end

  upre_front #(
    .MAX_MIN_LENGTH (MAX_MIN_LENGTH),
    .BUFFER_BYTES   (BUFFER_BYTES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (req_i.valid),
    .ready_o         (req_i.ready),
    .req_type_i      (req_i.req_type),
    .data_byte_i     (req_i.data_byte),
    .min_length_i    (min_length_q),
    .offset_enable_i (offset_enable_q),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data),
    .push_o          (push),
    .cmd_o           (push_cmd),
    .full_i          (full),
    .hold_i          (hold)
  );

  upre_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (empty)
  );

  upre_ram #(
    .WIDTH (upre_pkg::BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  upre_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .cmd_i        (head_cmd),
    .pop_o        (pop),
    .hold_o       (hold),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .valid_o      (rsp_o.valid),
    .ready_i      (rsp_o.ready),
    .kind_o       (rsp_o.kind),
    .out_byte_o   (rsp_o.out_byte),
    .run_offset_o (rsp_o.run_offset),
    .last_o       (rsp_o.last)
  );

endmodule

FILE: test/testbench.sv
// self-checking testbench of the utf-8 printable run extractor with a predictor and random traffic
`timescale 1ns / 100ps

module testbench;

  localparam int LEN_CAP       =
    (upre_pkg::MAX_MIN_LENGTH_DEF < upre_pkg::BUFFER_BYTES_DEF / 4) ?
    upre_pkg::MAX_MIN_LENGTH_DEF : upre_pkg::BUFFER_BYTES_DEF / 4;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 10;

  typedef struct {
    upre_pkg::req_e  req;
    logic [7:0]      data;
  } byte_req_t;

  typedef struct {
    upre_pkg::kind_e kind;
    logic [7:0]      data;
    logic [63:0]     offset;
    logic            last;
  } run_rec_t;

  logic clk_i;
  logic rst_ni;

  upre_cfg_if cfg_bus ();
  upre_req_if req_bus ();
  upre_rsp_if rsp_bus ();

  utf8_printable_run_extractor_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  byte_req_t   pending_bytes[$];
  run_rec_t    expected_records[$];
  int          items_queued;
  int          items_taken;
  int          err_count;
  bit          calm;
  bit          req_fire;
  int          gap_left;
  int          stall_left;
  byte_req_t   next_item;
  run_rec_t    seen_rec;

  // predictor state
  logic [3:0]  len_reg;
  logic        off_en_reg;
  logic [3:0]  dfa_q;
  logic [20:0] cp_q;
  logic [7:0]  run_buf [upre_pkg::BUFFER_BYTES_DEF];
  int          buf_cnt;
  int          char_cnt;
  bit          run_fresh;
  logic [63:0] pos_q;
  bit          ovf_q;

  function automatic logic [3:0] class_of(input logic [7:0] b);
    if (b < 8'h80) return 4'd0;
    if (b < 8'h90) return 4'd1;
    if (b < 8'hA0) return 4'd9;
    if (b < 8'hC0) return 4'd7;
    if (b < 8'hC2) return 4'd8;
    if (b < 8'hE0) return 4'd2;
    if (b == 8'hE0) return 4'd10;
    if (b == 8'hED) return 4'd4;
    if (b < 8'hF0) return 4'd3;
    if (b == 8'hF0) return 4'd11;
    if (b < 8'hF4) return 4'd6;
    if (b == 8'hF4) return 4'd5;
    return 4'd8;
  endfunction

  function automatic logic [3:0] dfa_step(input logic [3:0] st, input logic [3:0] cls);
    logic [3:0] nxt;
    nxt = upre_pkg::ST_REJECT;
    unique case (st)
      upre_pkg::ST_ACCEPT: begin
        unique case (cls)
          4'd0: nxt = upre_pkg::ST_ACCEPT;
          4'd2: nxt = 4'd2;
          4'd3: nxt = 4'd3;
          4'd4: nxt = 4'd5;
          4'd5: nxt = 4'd8;
          4'd6: nxt = 4'd7;
          4'd10: nxt = 4'd4;
          4'd11: nxt = 4'd6;
          default: nxt = upre_pkg::ST_REJECT;
        endcase
      end
      4'd2: if (cls == 4'd1 || cls == 4'd7 || cls == 4'd9) nxt = upre_pkg::ST_ACCEPT;
      4'd3: if (cls == 4'd1 || cls == 4'd7 || cls == 4'd9) nxt = 4'd2;
      4'd4: if (cls == 4'd7) nxt = 4'd2;
      4'd5: if (cls == 4'd1 || cls == 4'd9) nxt = 4'd2;
      4'd6: if (cls == 4'd7 || cls == 4'd9) nxt = 4'd3;
      4'd7: if (cls == 4'd1 || cls == 4'd7 || cls == 4'd9) nxt = 4'd3;
      4'd8: if (cls == 4'd1) nxt = 4'd3;
      default: nxt = upre_pkg::ST_REJECT;
    endcase
    return nxt;
  endfunction

  function automatic bit visible_cp(input logic [20:0] cp);
    if (cp == 21'h09) return 1'b1;
    if (cp < 21'h20) return 1'b0;
    if (cp >= 21'h7F && cp < 21'hA0) return 1'b0;
    return 1'b1;
  endfunction

  task automatic clear_stream();
    dfa_q     = upre_pkg::ST_ACCEPT;
    cp_q      = '0;
    buf_cnt   = 0;
    char_cnt  = 0;
    run_fresh = 1'b1;
    pos_q     = '0;
    ovf_q     = 1'b0;
  endtask

  task automatic predict_runs(input upre_pkg::req_e req, input logic [7:0] b);
    run_rec_t    recs[$];
    run_rec_t    r;
    int          lim;
    bit          at_limit;
    bit          keep;
    logic [3:0]  cls;
    logic [7:0]  mask;
    logic [3:0]  st;
    logic [63:0] start;
    lim = (len_reg == 4'd0) ? 1 : int'(len_reg);
    if (lim > LEN_CAP) lim = LEN_CAP;
    at_limit = off_en_reg && (pos_q == '1);
    r.data   = '0;
    r.offset = '0;
    r.last   = 1'b0;
    keep     = 1'b1;
    if (req == upre_pkg::REQ_EOS) begin
      if (!ovf_q) begin
        if (at_limit) begin
          r.kind = upre_pkg::KIND_OVERFLOW;
          recs.push_back(r);
        end else if (char_cnt >= lim) begin
          r.kind = upre_pkg::KIND_END;
          recs.push_back(r);
        end
      end
      clear_stream();
    end else if (!ovf_q) begin
      if (at_limit) begin
        ovf_q  = 1'b1;
        r.kind = upre_pkg::KIND_OVERFLOW;
        recs.push_back(r);
      end else begin
        cls   = class_of(b);
        mask  = 8'hFF >> cls;
        start = pos_q;
        pos_q = pos_q + 64'd1;
        if (dfa_q == upre_pkg::ST_ACCEPT) cp_q = {13'd0, b & mask};
        else cp_q = {cp_q[14:0], b[5:0]};
        st = dfa_step(dfa_q, cls);
        if (st == upre_pkg::ST_ACCEPT && !visible_cp(cp_q)) st = upre_pkg::ST_REJECT;
        if (st == upre_pkg::ST_REJECT) begin
          if (char_cnt >= lim) begin
            r.kind = upre_pkg::KIND_END;
            recs.push_back(r);
          end
          buf_cnt   = 0;
          char_cnt  = 0;
          run_fresh = 1'b1;
          cp_q      = {13'd0, b & mask};
          st        = dfa_step(upre_pkg::ST_ACCEPT, cls);
          if (st == upre_pkg::ST_REJECT ||
              (st == upre_pkg::ST_ACCEPT && !visible_cp(cp_q))) begin
            st   = upre_pkg::ST_ACCEPT;
            keep = 1'b0;
          end
        end
        if (keep) begin
          if (buf_cnt < upre_pkg::BUFFER_BYTES_DEF) begin
            run_buf[buf_cnt] = b;
            buf_cnt++;
          end
          if (st == upre_pkg::ST_ACCEPT) begin
            char_cnt++;
            if (char_cnt >= lim) begin
              if (run_fresh) begin
                run_fresh = 1'b0;
                if (off_en_reg) begin
                  r.kind   = upre_pkg::KIND_OFFSET;
                  r.offset = start - 64'(buf_cnt - 1);
                  recs.push_back(r);
                  r.offset = '0;
                end
              end
              for (int i = 0; i < buf_cnt; i++) begin
                r.kind = upre_pkg::KIND_DATA;
                r.data = run_buf[i];
                recs.push_back(r);
              end
              buf_cnt  = 0;
              char_cnt = lim;
            end
          end
        end
        dfa_q = st;
      end
    end
    if (recs.size() > 0) recs[recs.size() - 1].last = 1'b1;
    foreach (recs[i]) expected_records.push_back(recs[i]);
  endtask

  task automatic push_item(input upre_pkg::req_e req, input logic [7:0] b);
    byte_req_t it;
    it.req  = req;
    it.data = b;
    pending_bytes.push_back(it);
    items_queued++;
  endtask

  task automatic push_data(input logic [7:0] b);
    push_item(upre_pkg::REQ_DATA, b);
  endtask

  function automatic logic [7:0] cont_byte(input logic [7:0] lo, input logic [7:0] hi);
    return 8'($urandom_range(lo, hi));
  endfunction

  // one character of text, mostly well formed, sometimes broken or raw noise
  task automatic add_char(output int n);
    int         sel;
    logic [7:0] lead;
    sel = $urandom_range(0, 99);
    n   = 1;
    if (sel < 40) begin
      push_data(($urandom_range(0, 15) == 0) ? 8'h09 : cont_byte(8'h20, 8'h7E));
    end else if (sel < 55) begin
      push_data(cont_byte(8'hC2, 8'hDF));
      push_data(cont_byte(8'h80, 8'hBF));
      n = 2;
    end else if (sel < 67) begin
      lead = cont_byte(8'hE0, 8'hEF);
      push_data(lead);
      if (lead == 8'hE0) push_data(cont_byte(8'hA0, 8'hBF));
      else if (lead == 8'hED) push_data(cont_byte(8'h80, 8'h9F));
      else push_data(cont_byte(8'h80, 8'hBF));
      push_data(cont_byte(8'h80, 8'hBF));
      n = 3;
    end else if (sel < 77) begin
      lead = cont_byte(8'hF0, 8'hF4);
      push_data(lead);
      if (lead == 8'hF0) push_data(cont_byte(8'h90, 8'hBF));
      else if (lead == 8'hF4) push_data(cont_byte(8'h80, 8'h8F));
      else push_data(cont_byte(8'h80, 8'hBF));
      push_data(cont_byte(8'h80, 8'hBF));
      push_data(cont_byte(8'h80, 8'hBF));
      n = 4;
    end else if (sel < 85) begin
      unique case ($urandom_range(0, 2))
        0: push_data(cont_byte(8'h00, 8'h08));
        1: push_data(cont_byte(8'h0A, 8'h1F));
        default: push_data(8'h7F);
      endcase
      if (sel > 82) begin
        push_data(8'hC2);
        push_data(cont_byte(8'h80, 8'h9F));
        n = 3;
      end
    end else if (sel < 94) begin
      push_data(cont_byte(8'hC2, 8'hF4));
      push_data(8'($urandom_range(0, 255)));
      n = 2;
    end else begin
      push_data(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_text(input int count);
    int done;
    int n;
    done = 0;
    if ($urandom_range(0, 2) == 0) begin
      for (int i = 0; i < LEN_CAP; i++) begin
        push_data(cont_byte(8'hF1, 8'hF3));
        push_data(cont_byte(8'h80, 8'hBF));
        push_data(cont_byte(8'h80, 8'hBF));
        push_data(cont_byte(8'h80, 8'hBF));
      end
      done = 4 * LEN_CAP;
    end
    while (done < count) begin
      if ($urandom_range(0, 99) < 4) begin
        push_item(upre_pkg::REQ_EOS, 8'($urandom_range(0, 255)));
        done++;
      end else begin
        add_char(n);
        done += n;
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (items_taken != items_queued || expected_records.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input upre_pkg::cfg_idx_e idx, input logic [3:0] value);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    if (idx == upre_pkg::CFG_MIN_LENGTH) len_reg = value;
    else off_en_reg = value[0];
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_mode(input logic [3:0] len, input logic en);
    write_reg(upre_pkg::CFG_MIN_LENGTH, len);
    write_reg(upre_pkg::CFG_OFFSET_EN, {3'($urandom_range(0, 7)), en});
  endtask

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = upre_pkg::CFG_MIN_LENGTH;
    cfg_bus.data      = '0;
    req_bus.valid     = 1'b0;
    req_bus.req_type  = upre_pkg::REQ_DATA;
    req_bus.data_byte = '0;
    rsp_bus.ready     = 1'b0;
    len_reg           = upre_pkg::MIN_LENGTH_RST;
    off_en_reg        = 1'b0;
    clear_stream();
    fork
      forever #6 clk_i = ~clk_i;
      begin
        repeat (12) @(posedge clk_i);
        @(negedge clk_i);
        rst_ni = 1'b1;
      end
    join_none
  end

  initial begin
    #8_000_000;
    $display("utf8_printable_run_extractor_unit regression: fail");
    $finish;
  end

  // input driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        req_bus.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 18) - 1;
        req_bus.valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        next_item = pending_bytes.pop_front();
        req_bus.valid     <= 1'b1;
        req_bus.req_type  <= next_item.req;
        req_bus.data_byte <= next_item.data;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_bus.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  // monitor: predict on input transfer, check on result transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_bus.valid && req_bus.ready;
      if (req_bus.valid && req_bus.ready) begin
        predict_runs(upre_pkg::req_e'(req_bus.req_type), req_bus.data_byte);
        items_taken++;
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_records.size() == 0) begin
          $error("unexpected result transfer: kind %0d byte %0h", rsp_bus.kind, rsp_bus.out_byte);
          err_count++;
        end else begin
          seen_rec = expected_records.pop_front();
          if (rsp_bus.kind !== seen_rec.kind) begin
            $error("kind: expected %0d, actual %0d", seen_rec.kind, rsp_bus.kind);
            err_count++;
          end
          if (rsp_bus.out_byte !== seen_rec.data) begin
            $error("out_byte: expected %0h, actual %0h", seen_rec.data, rsp_bus.out_byte);
            err_count++;
          end
          if (rsp_bus.run_offset !== seen_rec.offset) begin
            $error("run_offset: expected %0h, actual %0h", seen_rec.offset, rsp_bus.run_offset);
            err_count++;
          end
          if (rsp_bus.last !== seen_rec.last) begin
            $error("last: expected %0b, actual %0b", seen_rec.last, rsp_bus.last);
            err_count++;
          end
        end
      end
    end
  end

  initial begin
    logic [3:0] lens [8];
    logic       ens  [8];
    lens = '{4'd0, 4'd15, 4'd8, 4'd3, 4'd1, 4'd6, 4'd2, 4'd9};
    ens  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    @(posedge rst_ni);

    // reset settings: ascii run, control break, invalid byte, multi-byte forms
    push_data("H");
    push_data("i");
    push_data(8'h09);
    push_data("Y");
    push_data("o");
    push_data(8'h00);
    push_data(8'hFF);
    push_data("a");
    push_data("b");
    push_data(8'hC3);
    push_data(8'hA9);
    push_data(8'hE2);
    push_data(8'h82);
    push_data(8'hAC);
    push_data(8'hF0);
    push_data(8'h9F);
    push_data(8'h98);
    push_data(8'h80);
    push_data(8'h7F);
    push_data(8'hC2);
    push_data(8'h85);
    push_data(8'hE0);
    push_data(8'h41);
    push_item(upre_pkg::REQ_EOS, 8'hFF);
    push_item(upre_pkg::REQ_EOS, 8'h00);
    wait_idle();

    // shortest runs with start offsets, end of stream closing an open run
    set_mode(4'd1, 1'b1);
    push_data("a");
    push_item(upre_pkg::REQ_EOS, 8'h00);
    push_data(8'h0A);
    push_data("b");
    push_data(8'h80);
    push_data("c");
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      set_mode(lens[p], ens[p]);
      calm = (p == 7) || ($urandom_range(0, 3) == 0);
      random_text(PHASE_ITEMS);
      if ($urandom_range(0, 1) == 0) push_item(upre_pkg::REQ_EOS, 8'($urandom_range(0, 255)));
      wait_idle();
    end

    if (err_count == 0 && expected_records.size() == 0) begin
      $display("utf8_printable_run_extractor_unit regression: pass");
    end else begin
      $display("utf8_printable_run_extractor_unit regression: fail");
    end
    $finish;
  end

endmodule
